// ===== hw/rtl/nfha_pkg.sv =====
// ----------------------------------------------------------------------------
// nfha_pkg
// Shared constants, header entry type and sequencer states of the next-fit
// heap allocator.
// ----------------------------------------------------------------------------
package nfha_pkg;

	localparam int HEAP_WORDS   = 4096;
	localparam int HEADER_WORDS = 4;
	localparam int WORD_BYTES   = 8;

	localparam int AW      = $clog2(HEAP_WORDS);
	localparam int EW      = AW + 1;
	localparam int NW      = AW + 2;
	localparam int SIZE_W  = 15;
	localparam int REQ_W   = SIZE_W + 1 - $clog2(WORD_BYTES);
	localparam int LIMIT_W = 13;
	localparam int STAT_W  = 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [0:0] OP_ALLOC = 1'b0;
	localparam logic [0:0] OP_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
	localparam logic [STAT_W-1:0] ST_OOM = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

	localparam logic [PADDR_W-1:0] REG_LIMIT = 3'd0;

	typedef struct packed {
		logic          valid;
		logic          used;
		logic          prev_ok;
		logic [AW-1:0] prev;
		logic [AW-1:0] size;
	} hdr_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_A_CUR,
		S_A_CURCHK,
		S_A_WALK,
		S_A_EVAL,
		S_A_TAKE,
		S_A_WCUR,
		S_A_EXT,
		S_F_RD,
		S_F_CHK,
		S_F_PRD,
		S_F_PCHK,
		S_F_KILL,
		S_F_NXT,
		S_F_NCHK,
		S_F_END,
		S_RL_RD,
		S_RL_WR,
		S_FIN
	} state_t;

endpackage

// ===== hw/rtl/nfha_ram.sv =====
// ----------------------------------------------------------------------------
// nfha_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nfha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/next_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// next_fit_heap_allocator_unit
// Next-fit heap allocator over a word-addressed heap of inline block headers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries opcode, size_bytes and
//   block_address; output channel (out_valid/out_stall) carries exactly one
//   result_address/status transfer per input transfer, in order.
//   Allocate walks the block headers one at a time through the header
//   RAM (one read port, registered read). Free merges the freed block
//   with a free previous block and a free next block where it can.
//   One item is processed at a time; in_stall is high while an item is
//   in flight. A finished result sits in the output register, so the next
//   item is accepted while the receiver stalls; a second result then waits
//   until the first transfer completes.
//   After reset the header RAM is swept clear, one entry per cycle, over all
//   HEAP_WORDS (4096) entries; no item is accepted during that sweep.
//   heap_limit_words is written over the APB port at byte address 0, by the
//   user only while the block is idle (not enforced); reset value is 4096.
// ----------------------------------------------------------------------------
module next_fit_heap_allocator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           opcode,
	input  logic [nfha_pkg::SIZE_W-1:0]    size_bytes,
	input  logic [nfha_pkg::AW-1:0]        block_address,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [nfha_pkg::AW-1:0]        result_address,
	output logic [nfha_pkg::STAT_W-1:0]    status,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [nfha_pkg::PADDR_W-1:0]   paddr,
	input  logic [nfha_pkg::PDATA_W-1:0]   pwdata,
	output logic [nfha_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import nfha_pkg::*;

	localparam logic [NW-1:0] HDR_N = NW'(HEADER_WORDS);
	localparam logic [AW-1:0] HDR_A = AW'(HEADER_WORDS);

	state_t state_q, state_d;
	state_t ret_q;

	logic [AW-1:0]      clr_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [EW-1:0]      heap_end_q;
	logic [AW-1:0]      cursor_q;
	logic               cursor_valid_q;

	logic               op_q;
	logic [REQ_W-1:0]   req_q;
	logic [AW-1:0]      ba_q;
	logic [NW-1:0]      cur_q;
	logic [EW-1:0]      end_q;
	logic               pass_q;
	logic [AW-1:0]      tail_q;
	logic               tail_ok_q;
	hdr_t               ent_q;
	hdr_t               aux_q;
	logic [AW-1:0]      h_q;
	logic [AW-1:0]      kill_q;
	logic [AW-1:0]      link_q;
	logic [AW-1:0]      src_q;
	logic               second_q;
	logic [AW-1:0]      res_addr_q;
	logic [STAT_W-1:0]  res_status_q;
	logic               out_valid_q;
	logic [AW-1:0]      out_addr_q;
	logic [STAT_W-1:0]  out_status_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	hdr_t               ram_wdata;
	logic [AW-1:0]      ram_raddr;
	hdr_t               rd;

	logic               in_acc;
	logic               out_free;
	logic               reg_hit;
	logic               cfg_wr;
	logic               walk_in;
	logic               fit;
	logic [NW-1:0]      rd_next;
	logic [AW-1:0]      rem;
	logic               split;
	logic [NW-1:0]      take_next;
	logic [AW-1:0]      nb;
	logic [NW-1:0]      ext_end;
	logic [NW-1:0]      ext_data;
	logic               ext_fail;
	logic [NW-1:0]      h_next;
	logic               h_link;
	logic               merge_ok;
	logic               bad_free;
	logic               cur_ok;
	logic [AW-1:0]      free_h;

	nfha_ram #(
		.WIDTH ($bits(hdr_t)),
		.DEPTH (HEAP_WORDS)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	assign in_stall       = (state_q != S_IDLE);
	assign in_acc         = in_valid && !in_stall;
	assign out_free       = !out_valid_q || !out_stall;
	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign status         = out_status_q;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_LIMIT[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? PDATA_W'(limit_q) : '0;

	assign walk_in   = cur_q < NW'(end_q);
	assign fit       = rd.valid && !rd.used && (REQ_W'(rd.size) >= req_q);
	assign rd_next   = cur_q + HDR_N + NW'(rd.size);
	assign rem       = ent_q.size - req_q[AW-1:0];
	assign split     = rem > HDR_A;
	assign take_next = NW'(cur_q[AW-1:0]) + HDR_N + NW'(ent_q.size);
	assign nb        = cur_q[AW-1:0] + HDR_A + req_q[AW-1:0];
	assign ext_end   = NW'(heap_end_q) + HDR_N + NW'(req_q);
	assign ext_data  = NW'(heap_end_q) + HDR_N;
	assign ext_fail  = (ext_end > NW'(limit_q)) || (ext_end > NW'(HEAP_WORDS))
	                   || (ext_data >= NW'(HEAP_WORDS));
	assign h_next    = NW'(h_q) + HDR_N + NW'(ent_q.size);
	assign h_link    = h_next < NW'(heap_end_q);
	assign merge_ok  = rd.valid && !rd.used;
	assign bad_free  = (ba_q < HDR_A) || !rd.valid;
	assign cur_ok    = cursor_valid_q && rd.valid;
	assign free_h    = ba_q - HDR_A;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:    if (&clr_q) state_d = S_IDLE;
			S_IDLE:     if (in_acc) state_d = (opcode == OP_FREE) ? S_F_RD : S_A_CUR;
			S_A_CUR:    state_d = S_A_CURCHK;
			S_A_CURCHK: state_d = S_A_WALK;
			S_A_WALK: begin
				if (walk_in) state_d = S_A_EVAL;
				else if (pass_q) state_d = S_A_EXT;
			end
			S_A_EVAL: begin
				if (!rd.valid) state_d = pass_q ? S_A_EXT : S_A_WALK;
				else if (fit) state_d = S_A_TAKE;
				else state_d = S_A_WALK;
			end
			S_A_TAKE:   state_d = (split && take_next < NW'(heap_end_q)) ? S_RL_RD : S_A_WCUR;
			S_A_WCUR:   state_d = S_FIN;
			S_A_EXT:    state_d = S_FIN;
			S_F_RD:     state_d = S_F_CHK;
			S_F_CHK: begin
				if (bad_free) state_d = S_FIN;
				else state_d = rd.prev_ok ? S_F_PRD : S_F_NXT;
			end
			S_F_PRD:    state_d = S_F_PCHK;
			S_F_PCHK:   state_d = merge_ok ? S_F_KILL : S_F_NXT;
			S_F_KILL: begin
				if (h_link) state_d = S_RL_RD;
				else state_d = second_q ? S_F_END : S_F_NXT;
			end
			S_F_NXT:    state_d = h_link ? S_F_NCHK : S_F_END;
			S_F_NCHK:   state_d = merge_ok ? S_F_KILL : S_F_END;
			S_F_END:    state_d = S_FIN;
			S_RL_RD:    state_d = S_RL_WR;
			S_RL_WR:    state_d = ret_q;
			S_FIN:      if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_A_CUR:  ram_raddr = cursor_q;
			S_A_WALK: ram_raddr = cur_q[AW-1:0];
			S_A_TAKE: begin
				ram_we            = split;
				ram_waddr         = nb;
				ram_wdata.valid   = 1'b1;
				ram_wdata.used    = 1'b0;
				ram_wdata.prev_ok = 1'b1;
				ram_wdata.prev    = cur_q[AW-1:0];
				ram_wdata.size    = rem - HDR_A;
			end
			S_A_WCUR: begin
				ram_we         = 1'b1;
				ram_waddr      = cur_q[AW-1:0];
				ram_wdata      = ent_q;
				ram_wdata.used = 1'b1;
				if (split) ram_wdata.size = req_q[AW-1:0];
			end
			S_A_EXT: begin
				ram_we            = !ext_fail;
				ram_waddr         = heap_end_q[AW-1:0];
				ram_wdata.valid   = 1'b1;
				ram_wdata.used    = 1'b1;
				ram_wdata.prev_ok = tail_ok_q;
				ram_wdata.prev    = tail_q;
				ram_wdata.size    = req_q[AW-1:0];
			end
			S_F_RD:   ram_raddr = free_h;
			S_F_CHK: begin
				ram_we         = !bad_free;
				ram_waddr      = free_h;
				ram_wdata      = rd;
				ram_wdata.used = 1'b0;
			end
			S_F_PRD:  ram_raddr = ent_q.prev;
			S_F_PCHK: begin
				ram_we         = merge_ok;
				ram_waddr      = ent_q.prev;
				ram_wdata      = rd;
				ram_wdata.size = rd.size + HDR_A + ent_q.size;
			end
			S_F_KILL: begin
				ram_we          = 1'b1;
				ram_waddr       = kill_q;
				ram_wdata       = aux_q;
				ram_wdata.valid = 1'b0;
			end
			S_F_NXT:  ram_raddr = h_next[AW-1:0];
			S_F_NCHK: begin
				ram_we         = merge_ok;
				ram_waddr      = h_q;
				ram_wdata      = ent_q;
				ram_wdata.size = ent_q.size + HDR_A + rd.size;
			end
			S_RL_RD:  ram_raddr = link_q;
			S_RL_WR: begin
				ram_we            = 1'b1;
				ram_waddr         = link_q;
				ram_wdata         = rd;
				ram_wdata.prev    = src_q;
				ram_wdata.prev_ok = 1'b1;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			limit_q        <= LIMIT_W'(HEAP_WORDS);
			heap_end_q     <= '0;
			cursor_q       <= '0;
			cursor_valid_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_wr) limit_q <= pwdata[LIMIT_W-1:0];
			if (state_q == S_A_WCUR) begin
				cursor_q       <= cur_q[AW-1:0];
				cursor_valid_q <= 1'b1;
			end
			if (state_q == S_A_EXT && !ext_fail) begin
				heap_end_q     <= ext_end[EW-1:0];
				cursor_q       <= heap_end_q[AW-1:0];
				cursor_valid_q <= 1'b1;
			end
			if (state_q == S_F_END) begin
				cursor_q       <= h_q;
				cursor_valid_q <= 1'b1;
			end
			if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_acc) begin
				op_q      <= opcode;
				req_q     <= REQ_W'((17'(size_bytes) + 17'(WORD_BYTES - 1))
				             >> $clog2(WORD_BYTES));
				ba_q      <= block_address;
				tail_q    <= '0;
				tail_ok_q <= 1'b0;
				second_q  <= 1'b0;
			end
			S_A_CURCHK: begin
				pass_q <= !cur_ok;
				cur_q  <= cur_ok ? NW'(cursor_q) : '0;
				end_q  <= heap_end_q;
			end
			S_A_WALK: if (!walk_in && !pass_q) begin
				pass_q <= 1'b1;
				cur_q  <= '0;
				end_q  <= EW'(cursor_q);
			end
			S_A_EVAL: begin
				ent_q <= rd;
				if (!rd.valid) begin
					if (!pass_q) begin
						pass_q <= 1'b1;
						cur_q  <= '0;
						end_q  <= EW'(cursor_q);
					end
				end else if (!fit) begin
					if (rd_next == NW'(heap_end_q)) begin
						tail_q    <= cur_q[AW-1:0];
						tail_ok_q <= 1'b1;
					end
					cur_q <= rd_next;
				end
			end
			S_A_TAKE: begin
				link_q <= take_next[AW-1:0];
				src_q  <= nb;
				ret_q  <= S_A_WCUR;
			end
			S_A_WCUR: begin
				res_addr_q   <= cur_q[AW-1:0] + HDR_A;
				res_status_q <= ST_OK;
			end
			S_A_EXT: begin
				res_addr_q   <= ext_fail ? '0 : ext_data[AW-1:0];
				res_status_q <= ext_fail ? ST_OOM : ST_OK;
			end
			S_F_CHK: begin
				ent_q <= ram_wdata;
				h_q   <= free_h;
				if (bad_free) begin
					res_addr_q   <= '0;
					res_status_q <= ST_BAD;
				end
			end
			S_F_PCHK: if (merge_ok) begin
				aux_q  <= ent_q;
				kill_q <= h_q;
				ent_q  <= ram_wdata;
				h_q    <= ent_q.prev;
			end
			S_F_KILL: begin
				link_q <= h_next[AW-1:0];
				src_q  <= h_q;
				ret_q  <= second_q ? S_F_END : S_F_NXT;
			end
			S_F_NCHK: if (merge_ok) begin
				aux_q      <= rd;
				kill_q     <= h_next[AW-1:0];
				ent_q.size <= ent_q.size + HDR_A + rd.size;
				second_q   <= 1'b1;
			end
			S_F_END: begin
				res_addr_q   <= '0;
				res_status_q <= ST_OK;
			end
			S_FIN: if (out_free) begin
				out_addr_q   <= (op_q == OP_FREE) ? '0 : res_addr_q;
				out_status_q <= res_status_q;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		heap_end_q <= EW'(HEAP_WORDS))
		else $error("heap end beyond heap size");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_F_RD || state_q == S_A_CUR))
		else $error("accepted item not started");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_status_q == ST_OK || out_status_q == ST_OOM
		                 || out_status_q == ST_BAD))
		else $error("illegal status code");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_OK) |-> (out_addr_q == '0))
		else $error("failed request with nonzero address");
`endif

endmodule

// ===== tb/sv/nfha_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfha_checker
// Watches the request, result and register ports of the next-fit heap
// allocator, keeps its own copy of the heap headers, works out the expected
// address and status of every request and compares them in order.
// ----------------------------------------------------------------------------
module nfha_checker (
	input  logic                          clk,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          opcode,
	input  logic [nfha_pkg::SIZE_W-1:0]   size_bytes,
	input  logic [nfha_pkg::AW-1:0]       block_address,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [nfha_pkg::AW-1:0]       result_address,
	input  logic [nfha_pkg::STAT_W-1:0]   status,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [nfha_pkg::PADDR_W-1:0]  paddr,
	input  logic [nfha_pkg::PDATA_W-1:0]  pwdata,
	output int                            fail_count,
	output int                            pending
);
	import nfha_pkg::*;

	typedef struct {
		logic [AW-1:0]     addr;
		logic [STAT_W-1:0] stat;
	} alloc_result_t;

	int unsigned blk_size [HEAP_WORDS];
	int unsigned blk_prev [HEAP_WORDS];
	bit          blk_prev_ok [HEAP_WORDS];
	bit          blk_used [HEAP_WORDS];
	bit          hdr_valid [HEAP_WORDS];
	int unsigned limit_words;
	int unsigned heap_end;
	int unsigned cursor;
	bit          cursor_ok;
	int unsigned tail;
	bit          tail_ok;

	alloc_result_t expected_q[$];

	initial begin
		for (int i = 0; i < HEAP_WORDS; i++) begin
			blk_size[i] = 0;
			blk_prev[i] = 0;
			blk_prev_ok[i] = 0;
			blk_used[i] = 0;
			hdr_valid[i] = 0;
		end
		limit_words = 4096;
		heap_end = 0;
		cursor = 0;
		cursor_ok = 0;
		fail_count = 0;
		pending = 0;
	end

	function automatic int unsigned next_hdr(int unsigned h);
		return h + HEADER_WORDS + blk_size[h];
	endfunction

	function automatic void relink(int unsigned h);
		int unsigned n;
		n = next_hdr(h);
		if (n < heap_end && n < HEAP_WORDS) begin
			blk_prev[n] = h;
			blk_prev_ok[n] = 1;
		end
	endfunction

	function automatic void claim(int unsigned h, int unsigned req);
		int unsigned rem, nb;
		rem = blk_size[h] - req;
		if (rem > HEADER_WORDS) begin
			nb = h + HEADER_WORDS + req;
			blk_size[nb] = rem - HEADER_WORDS;
			blk_prev[nb] = h;
			blk_prev_ok[nb] = 1;
			blk_used[nb] = 0;
			hdr_valid[nb] = 1;
			relink(nb);
			blk_size[h] = req;
		end
		blk_used[h] = 1;
	endfunction

	function automatic int walk_fit(int unsigned start, int unsigned stop, int unsigned req);
		int unsigned cur, steps, n;
		cur = start;
		steps = 0;
		while (cur < stop && steps < HEAP_WORDS) begin
			if (cur >= HEAP_WORDS || !hdr_valid[cur])
				return -1;
			n = next_hdr(cur);
			if (!blk_used[cur] && blk_size[cur] >= req) begin
				claim(cur, req);
				return int'(cur);
			end
			if (n == heap_end) begin
				tail = cur;
				tail_ok = 1;
			end
			cur = n;
			steps++;
		end
		return -1;
	endfunction

	function automatic void merge(int unsigned a, int unsigned b);
		blk_size[a] += HEADER_WORDS + blk_size[b];
		hdr_valid[b] = 0;
		relink(a);
	endfunction

	function automatic alloc_result_t predict_result(logic op, logic [SIZE_W-1:0] sz,
			logic [AW-1:0] ba);
		alloc_result_t r;
		int unsigned req, new_end, data, h, n, p;
		int got;
		bit cur_ok;
		r.addr = '0;
		r.stat = ST_OK;
		if (op == OP_ALLOC) begin
			req = (int'(sz) + WORD_BYTES - 1) / WORD_BYTES;
			tail = 0;
			tail_ok = 0;
			got = -1;
			cur_ok = cursor_ok && cursor < HEAP_WORDS && hdr_valid[cursor];
			if (cur_ok)
				got = walk_fit(cursor, heap_end, req);
			if (got < 0)
				got = walk_fit(0, cur_ok ? cursor : heap_end, req);
			if (got >= 0) begin
				cursor = got;
				cursor_ok = 1;
				r.addr = AW'(got + HEADER_WORDS);
			end else begin
				new_end = heap_end + HEADER_WORDS + req;
				data = heap_end + HEADER_WORDS;
				if (new_end > limit_words || new_end > HEAP_WORDS || data >= HEAP_WORDS) begin
					r.stat = ST_OOM;
				end else begin
					h = heap_end;
					blk_size[h] = req;
					blk_prev[h] = tail;
					blk_prev_ok[h] = tail_ok;
					blk_used[h] = 1;
					hdr_valid[h] = 1;
					heap_end = new_end;
					cursor = h;
					cursor_ok = 1;
					r.addr = AW'(data);
				end
			end
		end else begin
			if (ba < HEADER_WORDS || !hdr_valid[ba - HEADER_WORDS]) begin
				r.stat = ST_BAD;
			end else begin
				h = ba - HEADER_WORDS;
				blk_used[h] = 0;
				if (blk_prev_ok[h]) begin
					p = blk_prev[h];
					if (p < HEAP_WORDS && hdr_valid[p] && !blk_used[p]) begin
						merge(p, h);
						h = p;
					end
				end
				n = next_hdr(h);
				if (n < heap_end && n < HEAP_WORDS && hdr_valid[n] && !blk_used[n])
					merge(h, n);
				cursor = h;
				cursor_ok = 1;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		alloc_result_t exp_r;
		if (psel && penable && pwrite && pready
		    && paddr[PADDR_W-1:2] == REG_LIMIT[PADDR_W-1:2])
			limit_words = pwdata[LIMIT_W-1:0];
		if (in_valid && !in_stall)
			expected_q.push_back(predict_result(opcode, size_bytes, block_address));
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result transfer addr=%0d status=%0d",
					$time, result_address, status);
			end else begin
				exp_r = expected_q.pop_front();
				if (result_address !== exp_r.addr) begin
					fail_count++;
					$display("%0t: result_address expected %0d actual %0d",
						$time, exp_r.addr, result_address);
				end
				if (status !== exp_r.stat) begin
					fail_count++;
					$display("%0t: status expected %0d actual %0d",
						$time, exp_r.stat, status);
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the next-fit heap allocator: directed corner requests, then
// random allocate/free traffic over several heap limits and idle patterns,
// with results checked by nfha_checker.
// ----------------------------------------------------------------------------
module tb_top;
	import nfha_pkg::*;

	localparam longint CYCLE_LIMIT = 20000000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                opcode;
	logic [SIZE_W-1:0]   size_bytes;
	logic [AW-1:0]       block_address;
	logic                out_valid;
	logic                out_stall;
	logic [AW-1:0]       result_address;
	logic [STAT_W-1:0]   status;
	logic                psel, penable, pwrite, pready;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata, prdata;

	int fail_count, pending;
	int idle_pct, stall_pct;
	int hold_cycles;
	bit hold_req;
	int sent, received;
	longint cycles;
	logic op_q[$];
	logic [AW-1:0] live_q[$];

	next_fit_heap_allocator_unit dut (.*);

	nfha_checker chk (
		.clk, .in_valid, .in_stall, .opcode, .size_bytes, .block_address,
		.out_valid, .out_stall, .result_address, .status,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.fail_count, .pending
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver side: random stall, or a long hold on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_cycles = 400;
			hold_req = 0;
		end
		if (hold_cycles > 0) begin
			out_stall = 1'b1;
			hold_cycles--;
		end else
			out_stall = ($urandom_range(99) < stall_pct);
	end

	// track granted blocks so that frees can hit live headers
	always @(posedge clk) begin
		logic op;
		if (out_valid && !out_stall && op_q.size() > 0) begin
			op = op_q.pop_front();
			received++;
			if (op == OP_ALLOC && status == ST_OK)
				live_q.push_back(result_address);
		end
	end

	task automatic send_item(logic op, logic [SIZE_W-1:0] sz, logic [AW-1:0] ba);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		opcode = op;
		size_bytes = sz;
		block_address = ba;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		op_q.push_back(op);
		sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (sent != received) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_limit(int unsigned v);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = REG_LIMIT;
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic random_item();
		int r, k;
		logic [SIZE_W-1:0] sz;
		r = $urandom_range(99);
		if (r < 50) begin
			k = $urandom_range(99);
			if (k < 85) sz = SIZE_W'($urandom_range(0, 300));
			else if (k < 95) sz = SIZE_W'($urandom_range(0, 4000));
			else sz = SIZE_W'($urandom_range(0, 32767));
			send_item(OP_ALLOC, sz, AW'($urandom));
		end else if (r < 88 && live_q.size() > 0) begin
			k = $urandom_range(live_q.size() - 1);
			send_item(OP_FREE, SIZE_W'($urandom), live_q[k]);
			if ($urandom_range(99) < 85)
				live_q.delete(k);
		end else
			send_item(OP_FREE, SIZE_W'($urandom), AW'($urandom));
	endtask

	task automatic run_phase(int unsigned lim, int ip, int sp, int n, bit hold);
		drain();
		write_limit(lim);
		idle_pct = ip;
		stall_pct = sp;
		for (int i = 0; i < n; i++) begin
			if (hold && i == n / 2)
				hold_req = 1;
			random_item();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_ALLOC;
		size_bytes = '0;
		block_address = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		hold_req = 0;
		sent = 0;
		received = 0;
		cycles = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		while (in_stall) @(negedge clk);

		// directed corners at the reset limit
		send_item(OP_FREE, '0, 12'd0);
		send_item(OP_FREE, '0, 12'd3);
		send_item(OP_FREE, '0, 12'd4);
		send_item(OP_FREE, '1, 12'd4095);
		send_item(OP_ALLOC, 15'd0, '0);
		send_item(OP_ALLOC, 15'd1, '0);
		send_item(OP_ALLOC, 15'd8, '1);
		send_item(OP_ALLOC, 15'd9, '0);
		send_item(OP_ALLOC, 15'd400, '0);
		send_item(OP_ALLOC, 15'd32767, '0);
		send_item(OP_FREE, '0, 12'd4);
		send_item(OP_FREE, '0, 12'd4);
		send_item(OP_FREE, '0, 12'd9);
		send_item(OP_FREE, '0, 12'd10);
		send_item(OP_ALLOC, 15'd0, '0);
		send_item(OP_FREE, '0, 12'd26);
		send_item(OP_ALLOC, 15'd100, '0);
		send_item(OP_ALLOC, 15'd7, '0);
		send_item(OP_ALLOC, 15'd32000, '0);
		send_item(OP_ALLOC, 15'd16384, '0);

		run_phase(4096, 0, 0, 220, 0);
		run_phase(8191, 76, 0, 180, 0);
		run_phase(600, 0, 76, 200, 1);
		run_phase(0, 10, 10, 150, 0);
		run_phase(1500, 10, 10, 150, 1);
		run_phase(4096, 0, 0, 120, 0);

		drain();
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/nfha_pkg.sv
hw/rtl/nfha_ram.sv
hw/rtl/next_fit_heap_allocator_unit.sv
tb/sv/nfha_checker.sv
tb/sv/tb_top.sv
